/* src/rps_pkg.sv */
`timescale 1ns / 1ps

package rps_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_BUDGET    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SESSION_BUDGET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_BUDGET = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEALTHY_TOTAL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NO_RELAY_TOTAL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRMS       = 3'd5;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_LINK_BUDGET    = 32'd30000;
    localparam logic [31:0] RST_SESSION_BUDGET = 32'd30000;
    localparam logic [31:0] RST_CONFIRM_BUDGET = 32'd15000;
    localparam logic [31:0] RST_HEALTHY_TOTAL  = 32'd120000;
    localparam logic [31:0] RST_NO_RELAY_TOTAL = 32'd300000;
    localparam logic [7:0]  RST_CONFIRMS       = 8'd3;

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_REPORT  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_LINK      = 3'd1,
        PH_SESSION   = 3'd2,
        PH_CONFIRM   = 3'd3,
        PH_SUCCEEDED = 3'd4,
        PH_FAILED    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_CONTINUE      = 3'd1,
        ACT_REQUEST       = 3'd2,
        ACT_COMMIT        = 3'd3,
        ACT_RESTORE_RELAY = 3'd4,
        ACT_SEARCH_RELAY  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        WHY_NONE           = 3'd0,
        WHY_TOTAL          = 3'd1,
        WHY_LINK           = 3'd2,
        WHY_SESSION        = 3'd3,
        WHY_CONFIRM        = 3'd4,
        WHY_RESTORE_FAILED = 3'd5,
        WHY_SUCCEEDED      = 3'd6
    } reason_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] now_ms;
        logic        start_mode;
        logic        link_ready;
        logic        session_ready;
        logic        check_passed;
        logic        restore_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]  phase_now;
        logic [2:0]  action;
        logic        is_terminal;
        logic [2:0]  end_reason;
        logic [7:0]  confirm_count;
        logic [63:0] phase_deadline;
        logic [63:0] total_deadline;
    } result_t;

    typedef struct packed {
        logic [31:0] link_phase_budget;
        logic [31:0] session_phase_budget;
        logic [31:0] confirm_phase_budget;
        logic [31:0] healthy_mode_total_budget;
        logic [31:0] no_relay_total_budget;
        logic [7:0]  confirmations_needed;
    } cfg_t;

    // Deadline arithmetic: time plus budget, clamped at all ones
    function automatic logic [63:0] sat_add(input logic [63:0] t, input logic [31:0] b);
        logic [64:0] s;
        s = {1'b0, t} + {33'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic reason_t timeout_reason(input phase_t ph);
        reason_t r;
        case (ph)
            PH_LINK:    r = WHY_LINK;
            PH_SESSION: r = WHY_SESSION;
            PH_CONFIRM: r = WHY_CONFIRM;
            default:    r = WHY_TOTAL;
        endcase
        return r;
    endfunction

endpackage

/* src/rps_cfg.sv */
`timescale 1ns / 1ps

module rps_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rps_pkg::cfg_t                      cfg
);

    rps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_phase_budget         <= rps_pkg::RST_LINK_BUDGET;
            cfg_reg.session_phase_budget      <= rps_pkg::RST_SESSION_BUDGET;
            cfg_reg.confirm_phase_budget      <= rps_pkg::RST_CONFIRM_BUDGET;
            cfg_reg.healthy_mode_total_budget <= rps_pkg::RST_HEALTHY_TOTAL;
            cfg_reg.no_relay_total_budget     <= rps_pkg::RST_NO_RELAY_TOTAL;
            cfg_reg.confirmations_needed      <= rps_pkg::RST_CONFIRMS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rps_pkg::REG_LINK_BUDGET:    cfg_reg.link_phase_budget    <= cfg_data;
                rps_pkg::REG_SESSION_BUDGET: cfg_reg.session_phase_budget <= cfg_data;
                rps_pkg::REG_CONFIRM_BUDGET: cfg_reg.confirm_phase_budget <= cfg_data;
                rps_pkg::REG_HEALTHY_TOTAL:  cfg_reg.healthy_mode_total_budget <= cfg_data;
                rps_pkg::REG_NO_RELAY_TOTAL: cfg_reg.no_relay_total_budget <= cfg_data;
                rps_pkg::REG_CONFIRMS:       cfg_reg.confirmations_needed <= cfg_data[7:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/rps_core.sv */
`timescale 1ns / 1ps

module rps_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  rps_pkg::item_t    item,
    input  rps_pkg::cfg_t     cfg,
    output rps_pkg::result_t  res
);

    rps_pkg::phase_t  phase_reg,  phase_next;
    logic             mode_reg,   mode_next;
    rps_pkg::reason_t reason_reg, reason_next;
    logic [7:0]       confirm_reg, confirm_next;
    logic             pending_reg, pending_next;
    logic [63:0]      pdl_reg,    pdl_next;
    logic [63:0]      tdl_reg,    tdl_next;

    rps_pkg::action_t act;
    logic             fail;
    rps_pkg::reason_t fail_why;
    logic             enter_confirm;
    logic             dl_load;
    logic [31:0]      dl_budget;
    logic             at_dl;
    logic [7:0]       cnt_inc;

    assign at_dl   = (item.now_ms == pdl_reg);
    assign cnt_inc = (confirm_reg == 8'hFF) ? confirm_reg : confirm_reg + 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        mode_next     = mode_reg;
        reason_next   = reason_reg;
        confirm_next  = confirm_reg;
        pending_next  = pending_reg;
        tdl_next      = tdl_reg;
        act           = rps_pkg::ACT_NONE;
        fail          = 1'b0;
        fail_why      = rps_pkg::WHY_TOTAL;
        enter_confirm = 1'b0;
        dl_load       = 1'b0;
        dl_budget     = cfg.link_phase_budget;

        case (item.op)
            rps_pkg::OP_BEGIN:
            begin
                mode_next    = item.start_mode;
                reason_next  = rps_pkg::WHY_NONE;
                confirm_next = '0;
                pending_next = 1'b0;
                tdl_next     = rps_pkg::sat_add(item.now_ms,
                                   item.start_mode ? cfg.no_relay_total_budget
                                                   : cfg.healthy_mode_total_budget);
                phase_next   = rps_pkg::PH_LINK;
                dl_load      = 1'b1;
                dl_budget    = cfg.link_phase_budget;
                act          = rps_pkg::ACT_CONTINUE;
            end
            rps_pkg::OP_OBSERVE:
            begin
                if (!(phase_reg inside {rps_pkg::PH_LINK, rps_pkg::PH_SESSION,
                                        rps_pkg::PH_CONFIRM}))
                begin
                    act = pending_reg ? rps_pkg::ACT_REQUEST : rps_pkg::ACT_NONE;
                end
                else if (item.now_ms >= tdl_reg)
                begin
                    fail     = 1'b1;
                    fail_why = rps_pkg::WHY_TOTAL;
                end
                else if (item.now_ms > pdl_reg)
                begin
                    fail     = 1'b1;
                    fail_why = rps_pkg::timeout_reason(phase_reg);
                end
                else
                begin
                    // from here on now is at or before the phase deadline
                    act      = rps_pkg::ACT_CONTINUE;
                    fail_why = rps_pkg::timeout_reason(phase_reg);
                    case (phase_reg)
                        rps_pkg::PH_LINK:
                        begin
                            if (item.link_ready && item.session_ready)
                                enter_confirm = 1'b1;
                            else if (item.link_ready)
                            begin
                                phase_next = rps_pkg::PH_SESSION;
                                dl_load    = 1'b1;
                                dl_budget  = cfg.session_phase_budget;
                            end
                            else
                                fail = at_dl;
                        end
                        rps_pkg::PH_SESSION:
                        begin
                            if (!item.link_ready)
                            begin
                                if (at_dl)
                                    fail = 1'b1;
                                else
                                begin
                                    confirm_next = '0;
                                    phase_next   = rps_pkg::PH_LINK;
                                    dl_load      = 1'b1;
                                    dl_budget    = cfg.link_phase_budget;
                                end
                            end
                            else if (item.session_ready)
                                enter_confirm = 1'b1;
                            else
                                fail = at_dl;
                        end
                        rps_pkg::PH_CONFIRM:
                        begin
                            if (!item.link_ready || !item.session_ready)
                            begin
                                if (at_dl)
                                    fail = 1'b1;
                                else
                                begin
                                    confirm_next = '0;
                                    dl_load      = 1'b1;
                                    if (!item.link_ready)
                                    begin
                                        phase_next = rps_pkg::PH_LINK;
                                        dl_budget  = cfg.link_phase_budget;
                                    end
                                    else
                                    begin
                                        phase_next = rps_pkg::PH_SESSION;
                                        dl_budget  = cfg.session_phase_budget;
                                    end
                                end
                            end
                            else if (item.check_passed)
                            begin
                                confirm_next = cnt_inc;
                                if (cnt_inc >= cfg.confirmations_needed)
                                begin
                                    pending_next = 1'b1;
                                    act          = rps_pkg::ACT_REQUEST;
                                end
                                else
                                    fail = at_dl;
                            end
                            else
                            begin
                                confirm_next = '0;
                                fail         = at_dl;
                            end
                        end
                        default: act = rps_pkg::ACT_NONE;
                    endcase

                    // reaching confirm restarts the count; a passed check counts once
                    if (enter_confirm)
                    begin
                        phase_next   = rps_pkg::PH_CONFIRM;
                        dl_load      = 1'b1;
                        dl_budget    = cfg.confirm_phase_budget;
                        confirm_next = {7'b0, item.check_passed};
                        if (item.check_passed && cfg.confirmations_needed <= 8'd1)
                        begin
                            pending_next = 1'b1;
                            act          = rps_pkg::ACT_REQUEST;
                        end
                    end
                end
            end
            rps_pkg::OP_REPORT:
            begin
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    if (item.now_ms >= tdl_reg)
                    begin
                        fail     = 1'b1;
                        fail_why = rps_pkg::WHY_TOTAL;
                    end
                    else if (!item.restore_ok)
                    begin
                        fail     = 1'b1;
                        fail_why = rps_pkg::WHY_RESTORE_FAILED;
                    end
                    else
                    begin
                        phase_next  = rps_pkg::PH_SUCCEEDED;
                        reason_next = rps_pkg::WHY_SUCCEEDED;
                        act         = rps_pkg::ACT_COMMIT;
                    end
                end
            end
            default: act = rps_pkg::ACT_NONE;
        endcase

        if (fail)
        begin
            phase_next   = rps_pkg::PH_FAILED;
            reason_next  = fail_why;
            pending_next = 1'b0;
            act          = mode_reg ? rps_pkg::ACT_SEARCH_RELAY : rps_pkg::ACT_RESTORE_RELAY;
        end
    end

    assign pdl_next = dl_load ? rps_pkg::sat_add(item.now_ms, dl_budget) : pdl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rps_pkg::PH_IDLE;
            mode_reg    <= 1'b0;
            reason_reg  <= rps_pkg::WHY_NONE;
            confirm_reg <= '0;
            pending_reg <= 1'b0;
            pdl_reg     <= '0;
            tdl_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            mode_reg    <= mode_next;
            reason_reg  <= reason_next;
            confirm_reg <= confirm_next;
            pending_reg <= pending_next;
            pdl_reg     <= pdl_next;
            tdl_reg     <= tdl_next;
        end
    end

    always_comb
    begin
        res.phase_now      = phase_next;
        res.action         = act;
        res.is_terminal    = (phase_next == rps_pkg::PH_SUCCEEDED) ||
                             (phase_next == rps_pkg::PH_FAILED);
        res.end_reason     = reason_next;
        res.confirm_count  = confirm_next;
        res.phase_deadline = pdl_next;
        res.total_deadline = tdl_next;
    end

endmodule

/* src/recovery_phase_sequencer.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Carries
// item      in         item_valid, item_ready, item         one event transaction
// result    out        result_valid, result_ready, result   one result per event
// cfg       in         cfg_we, cfg_index, cfg_data          budget / threshold writes
//
// Each event goes through two register stages: an input register, then the
// sequencing logic (two 64-bit saturating adds plus compares) into the result
// register. Throughput is one transaction per cycle while results are taken.
// The phase state updates as the event moves into the result register, so the
// following event sees the new state. Reset is asynchronous, active low:
// phase idle, deadlines zero, budgets at defaults. A stalled result holds both
// stages; the input keeps accepting while its register is empty.

module recovery_phase_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               item_valid,
    output logic                               item_ready,
    input  rps_pkg::item_t                     item,

    output logic                               result_valid,
    input  logic                               result_ready,
    output rps_pkg::result_t                   result,

    input  logic                               cfg_we,
    input  logic [rps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rps_pkg::cfg_t    cfg;
    rps_pkg::item_t   item_reg;
    logic             item_valid_reg;
    rps_pkg::result_t result_reg;
    logic             result_valid_reg;
    rps_pkg::result_t core_res;
    logic             advance;

    // Event in the input register moves on when the result slot is free or draining
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    rps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rps_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    // Input stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    // Result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= core_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
